>>> rtl/cc20_pkg.sv
// Shared types and constants of the ChaCha20 stream cipher.
// No dependencies; every other file of the block refers to this package.
`default_nettype none
package cc20_pkg;

  localparam int BLOCK_BYTES   = 64;
  localparam int POS_W         = 7;
  localparam int DOUBLE_ROUNDS = 10;
  localparam int RND_W         = 5;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam logic [2:0] CFG_KEY_0_7    = 3'd0;
  localparam logic [2:0] CFG_KEY_8_15   = 3'd1;
  localparam logic [2:0] CFG_KEY_16_23  = 3'd2;
  localparam logic [2:0] CFG_KEY_24_31  = 3'd3;
  localparam logic [2:0] CFG_NONCE_0_7  = 3'd4;
  localparam logic [2:0] CFG_NONCE_8_11 = 3'd5;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       restart;
    logic       new_block;
  } item_t;

endpackage
`default_nettype wire

>>> rtl/cc20_front.sv
// Input side: accepts request bytes and tags each one that needs a fresh
// keystream block. Depends on cc20_pkg.
`default_nettype none
module cc20_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire logic [7:0]     s_tdata,   // data_in
  input  wire logic [0:0]     s_tuser,   // restart
  input  wire logic           s_tlast,   // last_in
  input  wire logic           q_ready,
  output logic                q_push,
  output cc20_pkg::item_t     q_item
);

  logic [cc20_pkg::POS_W-1:0] pos;
  logic [cc20_pkg::POS_W-1:0] pos_eff;
  logic                       need;

  assign s_tready = q_ready;
  assign q_push   = s_tvalid && q_ready;
  assign pos_eff  = s_tuser[0] ? cc20_pkg::POS_W'(cc20_pkg::BLOCK_BYTES) : pos;
  assign need     = (pos_eff == cc20_pkg::POS_W'(cc20_pkg::BLOCK_BYTES));

  always_comb begin
    q_item.data      = s_tdata;
    q_item.last      = s_tlast;
    q_item.restart   = s_tuser[0];
    q_item.new_block = need;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= cc20_pkg::POS_W'(cc20_pkg::BLOCK_BYTES);
    end else if (q_push) begin
      pos <= need ? cc20_pkg::POS_W'(1) : pos_eff + cc20_pkg::POS_W'(1);
    end
  end

endmodule
`default_nettype wire

>>> rtl/cc20_queue.sv
// Short first-in first-out queue of tagged bytes between front and back.
// Depends on cc20_pkg.
`default_nettype none
module cc20_queue #(
  parameter int DEPTH = cc20_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire cc20_pkg::item_t push_item,
  output logic                 ready,
  input  wire logic            pop,
  output logic                 valid,
  output cc20_pkg::item_t      head
);

  localparam int AW = $clog2(DEPTH);

  cc20_pkg::item_t mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;

  assign ready = (count != (AW+1)'(DEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/cc20_core.sv
// Block function: four quarter rounds side by side, one add-xor-rotate step
// per cycle, then the feed-forward add. Depends on cc20_pkg.
`default_nettype none
module cc20_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [255:0]   key,
  input  wire logic [31:0]    counter,
  input  wire logic [95:0]    nonce,
  output logic                done,
  output logic [511:0]        ks
);

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FINAL} cstate_t;

  cstate_t                    state;
  cc20_pkg::word_t            work [16];
  cc20_pkg::word_t            init [16];
  cc20_pkg::word_t            work_next [16];
  cc20_pkg::word_t            seed [16];
  logic [cc20_pkg::RND_W-1:0] rnd;
  logic [1:0]                 sub;

  always_comb begin
    seed[0]  = cc20_pkg::SIGMA0;
    seed[1]  = cc20_pkg::SIGMA1;
    seed[2]  = cc20_pkg::SIGMA2;
    seed[3]  = cc20_pkg::SIGMA3;
    for (int i = 0; i < 8; i++) begin
      seed[4+i] = key[32*i +: 32];
    end
    seed[12] = counter;
    seed[13] = nonce[31:0];
    seed[14] = nonce[63:32];
    seed[15] = nonce[95:64];
  end

  // Even rounds work on columns, odd rounds on diagonals.
  always_comb begin
    int ia, ib, ic, id, dg;
    cc20_pkg::word_t t, u;
    dg = int'(rnd[0]);
    for (int i = 0; i < 16; i++) begin
      work_next[i] = work[i];
    end
    for (int j = 0; j < 4; j++) begin
      ia = j;
      ib = 4 + ((j + dg) % 4);
      ic = 8 + ((j + 2 * dg) % 4);
      id = 12 + ((j + 3 * dg) % 4);
      case (sub)
        2'd0: begin
          t = work[ia] + work[ib];
          u = work[id] ^ t;
          work_next[ia] = t;
          work_next[id] = {u[15:0], u[31:16]};
        end
        2'd1: begin
          t = work[ic] + work[id];
          u = work[ib] ^ t;
          work_next[ic] = t;
          work_next[ib] = {u[19:0], u[31:20]};
        end
        2'd2: begin
          t = work[ia] + work[ib];
          u = work[id] ^ t;
          work_next[ia] = t;
          work_next[id] = {u[23:0], u[31:24]};
        end
        default: begin
          t = work[ic] + work[id];
          u = work[ib] ^ t;
          work_next[ic] = t;
          work_next[ib] = {u[24:0], u[31:25]};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
      rnd   <= '0;
      sub   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (start) begin
            for (int i = 0; i < 16; i++) begin
              init[i] <= seed[i];
              work[i] <= seed[i];
            end
            rnd   <= '0;
            sub   <= '0;
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          for (int i = 0; i < 16; i++) begin
            work[i] <= work_next[i];
          end
          sub <= sub + 2'd1;
          if (sub == 2'd3) begin
            if (rnd == cc20_pkg::RND_W'(2 * cc20_pkg::DOUBLE_ROUNDS - 1)) begin
              state <= C_FINAL;
            end else begin
              rnd <= rnd + cc20_pkg::RND_W'(1);
            end
          end
        end
        C_FINAL: begin
          for (int i = 0; i < 16; i++) begin
            work[i] <= work[i] + init[i];
          end
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      ks[32*i +: 32] = work[i];
    end
  end

endmodule
`default_nettype wire

>>> rtl/cc20_back.sv
// Output side: requests blocks from the round unit, shifts keystream bytes
// out and XORs them onto queued bytes. Depends on cc20_pkg.
`default_nettype none
module cc20_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire cc20_pkg::item_t q_head,
  output logic                 q_pop,
  output logic                 blk_start,
  output logic [31:0]          blk_counter,
  input  wire logic            blk_done,
  input  wire logic [511:0]    blk_ks,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [7:0]           m_tdata,   // data_out
  output logic                 m_tlast    // last_out
);

  typedef enum logic {B_RUN, B_WAIT} bstate_t;

  bstate_t      state;
  logic [31:0]  counter;
  logic         block_ready;
  logic [511:0] ks_sr;
  logic         out_free;

  assign out_free    = !m_tvalid || m_tready;
  assign blk_start   = (state == B_RUN) && q_valid && q_head.new_block && !block_ready;
  assign blk_counter = q_head.restart ? 32'd1 : counter;
  assign q_pop       = (state == B_RUN) && q_valid && out_free
                       && (!q_head.new_block || block_ready);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_tdata <= q_head.data ^ ks_sr[7:0];
      m_tlast <= q_head.last;
      ks_sr   <= {8'd0, ks_sr[511:8]};
    end else if (blk_done) begin
      ks_sr <= blk_ks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_RUN;
      counter     <= 32'd1;
      block_ready <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (q_pop) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        B_RUN: begin
          if (blk_start) begin
            counter <= blk_counter + 32'd1;
            state   <= B_WAIT;
          end else if (q_pop) begin
            block_ready <= 1'b0;
          end
        end
        B_WAIT: begin
          if (blk_done) begin
            block_ready <= 1'b1;
            state       <= B_RUN;
          end
        end
        default: state <= B_RUN;
      endcase
    end
  end

  a_start_in_run: assert property (@(posedge clk) disable iff (rst)
    blk_start |=> state == B_WAIT)
    else $error("block start did not enter wait");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    blk_done |-> state == B_WAIT)
    else $error("block finished while none was requested");
  a_pop_has_block: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (!q_head.new_block || block_ready))
    else $error("byte consumed without its keystream block");
  a_pop_shows: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> m_tvalid)
    else $error("consumed byte not presented");

endmodule
`default_nettype wire

>>> rtl/chacha20_stream_cipher.sv
// ChaCha20 stream cipher top level: configuration registers, front, queue,
// round unit and back. Depends on cc20_pkg and all cc20_* modules.
//
// Each request byte is XORed with the next keystream byte and leaves with its
// tlast mark. Within a 64-byte block the block moves one byte per cycle while
// bytes are queued and the output is free; a new block runs the round unit
// (80 add-xor-rotate steps, one feed-forward add, handover) while the output
// pauses and the input queue fills. Key and nonce are sampled at block start.
`default_nettype none
module chacha20_stream_cipher #(
  parameter int QUEUE_DEPTH = cc20_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,    // data_in
  input  wire logic [0:0]  s_tuser,    // restart
  input  wire logic        s_tlast,    // last_in
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,    // data_out
  output logic             m_tlast,    // last_out
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [255:0]    key;
  logic [95:0]     nonce;
  logic            q_push;
  logic            q_ready;
  logic            q_pop;
  logic            q_valid;
  cc20_pkg::item_t q_item;
  cc20_pkg::item_t q_head;
  logic            blk_start;
  logic            blk_done;
  logic [31:0]     blk_counter;
  logic [511:0]    blk_ks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key   <= '0;
      nonce <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        cc20_pkg::CFG_KEY_0_7:    key[63:0]    <= cfg_data;
        cc20_pkg::CFG_KEY_8_15:   key[127:64]  <= cfg_data;
        cc20_pkg::CFG_KEY_16_23:  key[191:128] <= cfg_data;
        cc20_pkg::CFG_KEY_24_31:  key[255:192] <= cfg_data;
        cc20_pkg::CFG_NONCE_0_7:  nonce[63:0]  <= cfg_data;
        cc20_pkg::CFG_NONCE_8_11: nonce[95:64] <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  cc20_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  cc20_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  cc20_core u_core (
    .clk     (clk),
    .rst     (rst),
    .start   (blk_start),
    .key     (key),
    .counter (blk_counter),
    .nonce   (nonce),
    .done    (blk_done),
    .ks      (blk_ks)
  );

  cc20_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .blk_start   (blk_start),
    .blk_counter (blk_counter),
    .blk_done    (blk_done),
    .blk_ks      (blk_ks),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule
`default_nettype wire

>>> sim/chacha20_stream_cipher_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for chacha20_stream_cipher: drives byte requests and
// register writes and compares every output byte with a built-in ChaCha20 model.
// Depends on cc20_pkg and the RTL of the block; reads no files.
module chacha20_stream_cipher_tb;

  localparam logic [2:0] CFG_SPARE_LOW  = 3'd6;
  localparam logic [2:0] CFG_SPARE_HIGH = 3'd7;
  localparam int SETTLE_CYCLES = 120;
  localparam int LONG_HOLD     = 400;
  localparam int MAX_LINES     = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic [0:0]  s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [63:0] cfg_data = 64'd0;

  cipher_out_t expected_out_q[$];
  int          err_count = 0;
  bit          idle_on = 1'b0;
  logic        hold_active = 1'b0;
  int          ready_run = 0;
  event        hold_start;

  bit [63:0] key_reg [6];
  bit [31:0] ks_counter = 32'd1;
  bit [7:0]  ks_store [cc20_pkg::BLOCK_BYTES];
  int        ks_pos = cc20_pkg::BLOCK_BYTES;
  bit [31:0] mix_w [16];

  chacha20_stream_cipher dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit [31:0] rotl(input bit [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void quarter_round(input int a, input int b, input int c, input int d);
    mix_w[a] += mix_w[b]; mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 16);
    mix_w[c] += mix_w[d]; mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 12);
    mix_w[a] += mix_w[b]; mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 8);
    mix_w[c] += mix_w[d]; mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 7);
  endfunction

  function automatic void fill_keystream();
    bit [31:0] init_w [16];
    bit [31:0] v;
    init_w[0] = cc20_pkg::SIGMA0;
    init_w[1] = cc20_pkg::SIGMA1;
    init_w[2] = cc20_pkg::SIGMA2;
    init_w[3] = cc20_pkg::SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init_w[4 + 2 * i] = key_reg[i][31:0];
      init_w[5 + 2 * i] = key_reg[i][63:32];
    end
    init_w[12] = ks_counter;
    init_w[13] = key_reg[cc20_pkg::CFG_NONCE_0_7][31:0];
    init_w[14] = key_reg[cc20_pkg::CFG_NONCE_0_7][63:32];
    init_w[15] = key_reg[cc20_pkg::CFG_NONCE_8_11][31:0];
    mix_w = init_w;
    for (int r = 0; r < cc20_pkg::DOUBLE_ROUNDS; r++) begin
      quarter_round(0, 4, 8, 12);
      quarter_round(1, 5, 9, 13);
      quarter_round(2, 6, 10, 14);
      quarter_round(3, 7, 11, 15);
      quarter_round(0, 5, 10, 15);
      quarter_round(1, 6, 11, 12);
      quarter_round(2, 7, 8, 13);
      quarter_round(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) begin
      v = mix_w[i] + init_w[i];
      for (int k = 0; k < 4; k++) ks_store[4 * i + k] = v[8 * k +: 8];
    end
  endfunction

  function automatic cipher_out_t predict_cipher(input logic [7:0] d, input logic rs,
                                                 input logic lst);
    cipher_out_t r;
    if (rs) begin
      ks_counter = 32'd1;
      ks_pos = cc20_pkg::BLOCK_BYTES;
    end
    if (ks_pos >= cc20_pkg::BLOCK_BYTES) begin
      fill_keystream();
      ks_counter += 32'd1;
      ks_pos = 0;
    end
    r.data = d ^ ks_store[ks_pos[5:0]];
    r.last = lst;
    ks_pos++;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_LINES) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  always @(posedge clk) begin : check_results
    cipher_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_out_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
      end else begin
        want = expected_out_q.pop_front();
        if (m_tdata !== want.data)
          report_mismatch($sformatf("data %02h, want %02h", m_tdata, want.data));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", m_tlast, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      ready_run <= 0;
    end else if (hold_active) begin
      m_tready <= 1'b0;
    end else if (ready_run == 0) begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        ready_run <= $urandom_range(1, 13);
      end else begin
        m_tready <= 1'b1;
        ready_run <= $urandom_range(1, 20);
      end
    end else begin
      ready_run <= ready_run - 1;
    end
  end

  always begin
    @(hold_start);
    hold_active <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_active <= 1'b0;
  end

  task automatic send_byte(input logic [7:0] d, input logic rs, input logic lst);
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tuser <= rs;
    s_tlast <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_out_q.push_back(predict_cipher(d, rs, lst));
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= cc20_pkg::CFG_NONCE_8_11)
      key_reg[idx] = (idx == cc20_pkg::CFG_NONCE_8_11) ? {32'd0, val[31:0]} : val;
  endtask

  task automatic program_keys(input logic [63:0] k0, input logic [63:0] k1,
                              input logic [63:0] k2, input logic [63:0] k3,
                              input logic [63:0] n0, input logic [63:0] n1);
    write_reg(cc20_pkg::CFG_KEY_0_7, k0);
    write_reg(cc20_pkg::CFG_KEY_8_15, k1);
    write_reg(cc20_pkg::CFG_KEY_16_23, k2);
    write_reg(cc20_pkg::CFG_KEY_24_31, k3);
    write_reg(cc20_pkg::CFG_NONCE_0_7, n0);
    write_reg(cc20_pkg::CFG_NONCE_8_11, n1);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic test_zero_key();
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
  endtask

  task automatic test_rfc_vector();
    logic [7:0] text [10];
    text = '{8'h4c, 8'h61, 8'h64, 8'h69, 8'h65, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h80};
    wait_drained();
    program_keys(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                 64'h1716151413121110, 64'h1f1e1d1c1b1a1918,
                 64'h4a00000000000000, 64'h0000000000000000);
    for (int i = 0; i < 10; i++) send_byte(text[i], i == 0, i[0]);
  endtask

  task automatic test_register_edges();
    wait_drained();
    write_reg(cc20_pkg::CFG_KEY_0_7, '1);
    write_reg(cc20_pkg::CFG_KEY_8_15, '1);
    write_reg(cc20_pkg::CFG_KEY_16_23, '1);
    write_reg(cc20_pkg::CFG_KEY_24_31, '1);
    write_reg(cc20_pkg::CFG_NONCE_0_7, '1);
    write_reg(cc20_pkg::CFG_NONCE_8_11, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(cc20_pkg::CFG_NONCE_8_11, 64'hA5A5_5A5A_0000_0001);
    write_reg(CFG_SPARE_LOW, rand_word());
    write_reg(CFG_SPARE_HIGH, rand_word());
    cfg_valid <= 1'b0;
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h0F, 1'b0, 1'b1);
    send_byte(8'hF0, 1'b1, 1'b1);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b1);
  endtask

  task automatic test_random_stream();
    int n;
    logic [2:0] idx;
    for (int phase = 0; phase < 10; phase++) begin
      wait_drained();
      case ($urandom_range(0, 4))
        0: program_keys('0, '0, '0, '0, '0, '0);
        1: program_keys('1, '1, '1, '1, '1, '1);
        2, 3: program_keys(rand_word(), rand_word(), rand_word(), rand_word(),
                           rand_word(), rand_word());
        default: begin
          idx = 3'($urandom_range(0, 7));
          write_reg(idx, rand_word());
          cfg_valid <= 1'b0;
        end
      endcase
      idle_on = $urandom_range(0, 3) != 0;
      n = $urandom_range(100, 196);
      for (int i = 0; i < n; i++)
        send_byte(rand_byte(), $urandom_range(0, 79) == 0, $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    -> hold_start;
    for (int i = 0; i < 150; i++)
      send_byte(rand_byte(), $urandom_range(0, 99) == 0, $urandom_range(0, 7) == 0);
    wait_drained();
    idle_on = 1'b1;
    for (int i = 0; i < 30; i++)
      send_byte(rand_byte(), 1'b0, $urandom_range(0, 3) == 0);
  endtask

  task automatic test_steady_tail();
    wait_drained();
    program_keys(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
    idle_on = 1'b0;
    for (int i = 0; i < 200; i++)
      send_byte(rand_byte(), i == 0, $urandom_range(0, 7) == 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_zero_key();
    test_rfc_vector();
    test_register_edges();
    test_random_stream();
    test_backpressure();
    test_steady_tail();
    wait_drained();
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> files.f
rtl/cc20_pkg.sv
rtl/cc20_front.sv
rtl/cc20_queue.sv
rtl/cc20_core.sv
rtl/cc20_back.sv
rtl/chacha20_stream_cipher.sv
sim/chacha20_stream_cipher_tb.sv
